/* rtl/positional_list_engine_assert.svh */
// Assertion macros for the positional list engine.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Check a property on every rising edge, disabled while reset is applied.
`define PLE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define PLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes of the positional list engine: request and result
// words, request and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int HANDLE_BITS_DEF = 11;

  // Request codes
  localparam logic [2:0] REQ_INS_HEAD = 3'd0;
  localparam logic [2:0] REQ_INS_TAIL = 3'd1;
  localparam logic [2:0] REQ_INS_POS  = 3'd2;
  localparam logic [2:0] REQ_REM_HEAD = 3'd3;
  localparam logic [2:0] REQ_REM_TAIL = 3'd4;
  localparam logic [2:0] REQ_REM_POS  = 3'd5;

  // Status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [6:0]  position;
    logic [10:0] handle;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] removed_handle;
    logic [6:0]  entry_count;
  } rsp_word_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic     apply;
    cell_op_t op;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/ple_cell.sv */
// ----------------------------------------------------------------------------
// ple_cell
// One entry of the list chain. On an insert, cells past the insert point take
// their left neighbor and the cell at the point loads the new handle; on a
// remove, cells from the point on take their right neighbor. The cell at a
// remove point drives its entry onto the pick output, else zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell #(
  parameter int INDEX       = 0,
  parameter int HANDLE_BITS = ple_pkg::HANDLE_BITS_DEF,
  parameter int CMP_W       = 7
) (
  input  wire logic                   clk,
  input  wire ple_pkg::cell_ctl_t     ctl_i,
  input  wire logic [CMP_W-1:0]       at_i,
  input  wire logic [HANDLE_BITS-1:0] new_i,
  input  wire logic [HANDLE_BITS-1:0] left_i,
  input  wire logic [HANDLE_BITS-1:0] right_i,
  output logic      [HANDLE_BITS-1:0] entry_o,
  output logic      [HANDLE_BITS-1:0] pick_o
);

  localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

  logic [HANDLE_BITS-1:0] entry_r;
  logic [HANDLE_BITS-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl_i.apply) begin
      unique case (ctl_i.op)
        ple_pkg::CELL_INSERT: begin
          if (IDX > at_i) begin
            entry_nxt = left_i;
          end else if (IDX == at_i) begin
            entry_nxt = new_i;
          end
        end
        ple_pkg::CELL_REMOVE: begin
          if (IDX >= at_i) begin
            entry_nxt = right_i;
          end
        end
        default: entry_nxt = entry_r;
      endcase
    end
  end

  // Payload only: entries above the count are never read.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign pick_o  = (ctl_i.op == ple_pkg::CELL_REMOVE && IDX == at_i) ? entry_r : '0;

endmodule

`default_nettype wire

/* rtl/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH handles held in a shifting chain of cells.
// Inserts and removes at head, tail or a position, one result word per request.
// ----------------------------------------------------------------------------
//   channel  direction  word        handshake
//   in_      input      req_word_t  in_valid / in_stall
//   out_     output     rsp_word_t  out_valid / out_stall
//
// The whole cell chain shifts at the accept edge
// and the result word is registered at that same edge.
// The removed handle is picked from the cell at the remove point through an OR
// of the cell outputs.
// Reset clears the count and the output valid; cell contents are not reset.
// in_stall rises only while a result word waits and out_stall is high.
`default_nettype none

`include "positional_list_engine_assert.svh"

module positional_list_engine #(
  parameter int DEPTH       = ple_pkg::DEPTH_DEF,
  parameter int HANDLE_BITS = ple_pkg::HANDLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ple_pkg::req_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ple_pkg::rsp_word_t      out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic                   out_valid_r;
  ple_pkg::rsp_word_t     out_data_r;
  logic                   accept;
  logic                   full;
  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       pos_ext;
  logic [CMP_W-1:0]       at;
  logic [1:0]             status;
  ple_pkg::cell_ctl_t     ctl;
  logic [HANDLE_BITS-1:0] new_handle;
  logic [HANDLE_BITS-1:0] removed;
  logic [HANDLE_BITS-1:0] entry_q [DEPTH];
  logic [HANDLE_BITS-1:0] pick_q  [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign cnt_ext  = CMP_W'(count_r);
  assign pos_ext  = CMP_W'(in_data.position);
  assign new_handle = HANDLE_BITS'(in_data.handle);

  always_comb begin
    logic ins;
    logic rem;
    ins       = 1'b0;
    rem       = 1'b0;
    at        = '0;
    status    = ple_pkg::ST_NONE;
    count_nxt = count_r;
    unique case (in_data.req_type)
      ple_pkg::REQ_INS_HEAD: begin
        ins = 1'b1;
      end
      ple_pkg::REQ_INS_TAIL: begin
        ins = 1'b1;
        at  = cnt_ext;
      end
      ple_pkg::REQ_INS_POS: begin
        if (pos_ext <= cnt_ext) begin
          ins = 1'b1;
          at  = pos_ext;
        end
      end
      ple_pkg::REQ_REM_HEAD: begin
        rem = (count_r != '0);
      end
      ple_pkg::REQ_REM_TAIL: begin
        rem = (count_r != '0);
        at  = cnt_ext - CMP_W'(1);
      end
      ple_pkg::REQ_REM_POS: begin
        if (pos_ext < cnt_ext) begin
          rem = 1'b1;
          at  = pos_ext;
        end
      end
      default: begin
        ins = 1'b0;
      end
    endcase

    ctl.apply = accept;
    ctl.op    = ple_pkg::CELL_HOLD;
    if (ins) begin
      if (full) begin
        status = ple_pkg::ST_FULL;
      end else begin
        ctl.op    = ple_pkg::CELL_INSERT;
        status    = ple_pkg::ST_DONE;
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (rem) begin
      ctl.op    = ple_pkg::CELL_REMOVE;
      status    = ple_pkg::ST_DONE;
      count_nxt = count_r - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HANDLE_BITS-1:0] left_d;
    logic [HANDLE_BITS-1:0] right_d;

    if (i == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = entry_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = entry_q[i+1];
    end

    ple_cell #(
      .INDEX       (i),
      .HANDLE_BITS (HANDLE_BITS),
      .CMP_W       (CMP_W)
    ) u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .at_i    (at),
      .new_i   (new_handle),
      .left_i  (left_d),
      .right_i (right_d),
      .entry_o (entry_q[i]),
      .pick_o  (pick_q[i])
    );
  end

  // At most one cell drives a nonzero pick.
  always_comb begin
    removed = '0;
    for (int i = 0; i < DEPTH; i++) begin
      removed = removed | pick_q[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the word while stalled; load a new one on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.status         <= status;
      out_data_r.removed_handle <= 11'(removed);
      out_data_r.entry_count    <= 7'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PLE_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH), "count above depth")
  `PLE_ASSERT(a_full_keeps_count, clk, rst_n, accept && status == ple_pkg::ST_FULL |=> count_r == $past(count_r), "full insert changed count")
  `PLE_ASSERT(a_remove_count, clk, rst_n, accept && ctl.op == ple_pkg::CELL_REMOVE |=> count_r == $past(count_r) - CNT_W'(1), "remove did not drop count")
  `PLE_ASSERT(a_no_removed_word, clk, rst_n, accept && ctl.op != ple_pkg::CELL_REMOVE |=> out_data_r.removed_handle == '0, "removed handle without remove")

endmodule

`default_nettype wire
